>>> rtl/core/dbf_pkg.sv
// ----------------------------------------------------------------------------
// dbf_pkg: shared definitions for the detection box filter
// Row layout constants, register indexes, reset values and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package dbf_pkg;

  // Row layout: x, y, w, h, objectness, then the class scores
  localparam int BOX_FIELDS = 4;
  localparam int HEADER_LEN = 5;

  localparam int MAX_CLASSES_DEFAULT = 255;

  localparam int VALUE_W     = 32;
  localparam int COORD_W     = 16;
  localparam int ANCHOR_W    = 16;
  localparam int THRESHOLD_W = 17;
  localparam int CLASS_ID_W  = 8;

  // Configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 17;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_CLASS_COUNT    = 2'd0,
    CFG_ANCHOR_COUNT   = 2'd1,
    CFG_CONF_THRESHOLD = 2'd2
  } cfg_reg_t;

  localparam int CLASS_COUNT_RESET    = 80;
  localparam int ANCHOR_COUNT_RESET   = 25200;
  localparam int CONF_THRESHOLD_RESET = 32768;

  typedef struct packed {
    logic                         kept;
    logic [ANCHOR_W-1:0]          anchor_index;
    logic signed [COORD_W-1:0]    box_x;
    logic signed [COORD_W-1:0]    box_y;
    logic signed [COORD_W-1:0]    box_w;
    logic signed [COORD_W-1:0]    box_h;
    logic signed [VALUE_W-1:0]    score;
    logic [CLASS_ID_W-1:0]        class_index;
    logic                         frame_done;
  } dbf_result_t;

endpackage

`default_nettype wire

>>> rtl/core/dbf_if.sv
// ----------------------------------------------------------------------------
// dbf_if: stream channels of the detection box filter
// Tensor element channel and result channel, valid/ready with payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface dbf_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [dbf_pkg::VALUE_W-1:0]   value;
  logic                                 frame_start;

  modport source (output valid, output value, output frame_start, input ready);
  modport sink   (input valid, input value, input frame_start, output ready);
endinterface

interface dbf_out_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 kept;
  logic [dbf_pkg::ANCHOR_W-1:0]         anchor_index;
  logic signed [dbf_pkg::COORD_W-1:0]   box_x;
  logic signed [dbf_pkg::COORD_W-1:0]   box_y;
  logic signed [dbf_pkg::COORD_W-1:0]   box_w;
  logic signed [dbf_pkg::COORD_W-1:0]   box_h;
  logic signed [dbf_pkg::VALUE_W-1:0]   score;
  logic [dbf_pkg::CLASS_ID_W-1:0]       class_index;
  logic                                 frame_done;

  modport source (output valid, output kept, output anchor_index, output box_x,
                  output box_y, output box_w, output box_h, output score,
                  output class_index, output frame_done, input ready);
  modport sink   (input valid, input kept, input anchor_index, input box_x,
                  input box_y, input box_w, input box_h, input score,
                  input class_index, input frame_done, output ready);
endinterface

`default_nettype wire

>>> rtl/core/detection_box_filter_core.sv
// ----------------------------------------------------------------------------
// detection_box_filter_core: detector output confidence filter with argmax
// Streams a detector tensor and emits box, objectness and class per anchor.
// ----------------------------------------------------------------------------
// Usage:
//   tensor_ch carries one signed Q16.16 tensor element per transaction, rows
//   of x, y, w, h, objectness and class_count class scores; frame_start marks
//   the first element of a tensor and restarts the row and anchor counts.
//   result_ch carries at most one result per row, on its last element: rows
//   whose objectness is strictly above conf_threshold, and always the last
//   anchor of a tensor, flagged by frame_done, kept or not.
//   The config port (cfg_we, cfg_index, cfg_data) writes class_count,
//   anchor_count and conf_threshold; write only while the block is idle.
// Timing:
//   An element is held in the input register and updates the row state on
//   the edge at which it advances, which also loads the result register:
//   the row's last element passes the input register and then the result
//   register before its result can be taken. Throughput is one element per
//   cycle while result_ch does not stall, set by the single row-update stage.
// Reset and stall:
//   Reset empties both registers, clears the counters and restores the
//   register defaults. While result_ch stalls with a result held, the input
//   register holds and tensor_ch drops ready once that register is full.
// ----------------------------------------------------------------------------
`default_nettype none

module detection_box_filter_core #(
  parameter int MAX_CLASSES = dbf_pkg::MAX_CLASSES_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [dbf_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [dbf_pkg::CFG_DATA_W-1:0]    cfg_data,
  dbf_in_if.sink                                 tensor_ch,
  dbf_out_if.source                              result_ch
);

  localparam int CLASS_W = $clog2(MAX_CLASSES + 1);

  // Configuration registers
  logic [CLASS_W-1:0]                 class_count;
  logic [dbf_pkg::ANCHOR_W-1:0]       anchor_count;
  logic [dbf_pkg::THRESHOLD_W-1:0]    conf_threshold;

  // Input register
  logic                               in_valid;
  logic signed [dbf_pkg::VALUE_W-1:0] in_value;
  logic                               in_frame_start;

  // Result register
  logic                               out_valid;
  dbf_pkg::dbf_result_t               out_result;

  logic                               fire;
  logic                               row_valid;
  dbf_pkg::dbf_result_t               row_result;

  // Advance the held element whenever the result register can take a result
  assign fire            = in_valid && (!out_valid || result_ch.ready);
  assign tensor_ch.ready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      class_count    <= CLASS_W'(dbf_pkg::CLASS_COUNT_RESET);
      anchor_count   <= dbf_pkg::ANCHOR_W'(dbf_pkg::ANCHOR_COUNT_RESET);
      conf_threshold <= dbf_pkg::THRESHOLD_W'(dbf_pkg::CONF_THRESHOLD_RESET);
    end else if (cfg_we) begin
      case (dbf_pkg::cfg_reg_t'(cfg_index))
        dbf_pkg::CFG_CLASS_COUNT:    class_count    <= cfg_data[CLASS_W-1:0];
        dbf_pkg::CFG_ANCHOR_COUNT:   anchor_count   <= cfg_data[dbf_pkg::ANCHOR_W-1:0];
        dbf_pkg::CFG_CONF_THRESHOLD: conf_threshold <= cfg_data[dbf_pkg::THRESHOLD_W-1:0];
        default: ;  // drop writes to unmapped indexes
      endcase
    end
  end

  // Input register: load on every transaction, empty when advanced
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (tensor_ch.valid && tensor_ch.ready) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tensor_ch.valid && tensor_ch.ready) begin
      in_value       <= tensor_ch.value;
      in_frame_start <= tensor_ch.frame_start;
    end
  end

  dbf_row_tracker #(
    .MAX_CLASSES (MAX_CLASSES)
  ) u_row_tracker (
    .clk            (clk),
    .rst            (rst),
    .step           (fire),
    .value          (in_value),
    .frame_start    (in_frame_start),
    .class_count    (class_count),
    .anchor_count   (anchor_count),
    .conf_threshold (conf_threshold),
    .result_valid   (row_valid),
    .result         (row_result)
  );

  // Result register: a row that yields nothing still frees a taken slot
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= row_valid;
    end else if (result_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && row_valid) begin
      out_result <= row_result;
    end
  end

  assign result_ch.valid        = out_valid;
  assign result_ch.kept         = out_result.kept;
  assign result_ch.anchor_index = out_result.anchor_index;
  assign result_ch.box_x        = out_result.box_x;
  assign result_ch.box_y        = out_result.box_y;
  assign result_ch.box_w        = out_result.box_w;
  assign result_ch.box_h        = out_result.box_h;
  assign result_ch.score        = out_result.score;
  assign result_ch.class_index  = out_result.class_index;
  assign result_ch.frame_done   = out_result.frame_done;

  // A rejected row only reaches the output as the last anchor of a tensor
  a_reject_only_at_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_result.kept |-> out_result.frame_done)
    else $error("result neither kept nor last anchor");

  // A result formed by the row stage is offered on the next cycle
  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    fire && row_valid |=> out_valid)
    else $error("row result lost");

  // An empty input register always takes a transaction
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !in_valid |-> tensor_ch.ready)
    else $error("input register empty but not ready");

  // A full input register is only ready when its element can advance
  a_ready_needs_slot: assert property (@(posedge clk) disable iff (rst)
    in_valid && tensor_ch.ready |-> !out_valid || result_ch.ready)
    else $error("ready while result register blocked");

endmodule

`default_nettype wire

>>> rtl/core/dbf_row_tracker.sv
// ----------------------------------------------------------------------------
// dbf_row_tracker: row position, box hold and class argmax
// Consumes one tensor element per step and forms the result at row end.
// ----------------------------------------------------------------------------
`default_nettype none

module dbf_row_tracker #(
  parameter int MAX_CLASSES = dbf_pkg::MAX_CLASSES_DEFAULT,
  localparam int CLASS_W    = $clog2(MAX_CLASSES + 1),
  localparam int POS_W      = $clog2(MAX_CLASSES + dbf_pkg::HEADER_LEN)
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                step,
  input  wire logic signed [dbf_pkg::VALUE_W-1:0]  value,
  input  wire logic                                frame_start,
  input  wire logic [CLASS_W-1:0]                  class_count,
  input  wire logic [dbf_pkg::ANCHOR_W-1:0]        anchor_count,
  input  wire logic [dbf_pkg::THRESHOLD_W-1:0]     conf_threshold,
  output logic                                     result_valid,
  output dbf_pkg::dbf_result_t                     result
);

  localparam int BOX_IDX_W = $clog2(dbf_pkg::BOX_FIELDS);

  // Integer part of a Q16.16 value, truncated toward zero; always fits 16 bits
  function automatic logic signed [dbf_pkg::COORD_W-1:0] trunc_int(
    input logic signed [dbf_pkg::VALUE_W-1:0] q
  );
    logic round_up;
    round_up  = q[dbf_pkg::VALUE_W-1] & (|q[15:0]);
    trunc_int = q[dbf_pkg::VALUE_W-1:16] + {{(dbf_pkg::COORD_W-1){1'b0}}, round_up};
  endfunction

  logic [POS_W-1:0]                   element_position;
  logic [dbf_pkg::ANCHOR_W-1:0]       anchor_counter;
  logic signed [dbf_pkg::COORD_W-1:0] box_store [dbf_pkg::BOX_FIELDS];
  logic signed [dbf_pkg::VALUE_W-1:0] objectness_hold;
  logic signed [dbf_pkg::VALUE_W-1:0] best_score;
  logic [CLASS_W-1:0]                 best_class;

  logic [POS_W-1:0]                   pos;
  logic [dbf_pkg::ANCHOR_W-1:0]       anchor;
  logic [POS_W-1:0]                   last_pos;
  logic                               row_end;
  logic                               kept;
  logic                               done;
  logic signed [dbf_pkg::COORD_W-1:0] box_next [dbf_pkg::BOX_FIELDS];
  logic signed [dbf_pkg::VALUE_W-1:0] objectness_next;
  logic signed [dbf_pkg::VALUE_W-1:0] best_score_next;
  logic [CLASS_W-1:0]                 best_class_next;

  // A new tensor clears position and anchor before the element is used
  assign pos      = frame_start ? '0 : element_position;
  assign anchor   = frame_start ? '0 : anchor_counter;
  assign last_pos = POS_W'(class_count) + POS_W'(dbf_pkg::HEADER_LEN - 1);
  assign row_end  = pos >= last_pos;

  always_comb begin
    box_next        = box_store;
    objectness_next = objectness_hold;
    best_score_next = best_score;
    best_class_next = best_class;
    if (pos < POS_W'(dbf_pkg::BOX_FIELDS)) begin
      box_next[pos[BOX_IDX_W-1:0]] = trunc_int(value);
    end else if (pos == POS_W'(dbf_pkg::BOX_FIELDS)) begin
      objectness_next = value;
      best_class_next = '0;
    end else if (pos == POS_W'(dbf_pkg::HEADER_LEN)) begin
      best_score_next = value;
      best_class_next = '0;
    end else if (value > best_score) begin
      best_score_next = value;
      best_class_next = CLASS_W'(pos - POS_W'(dbf_pkg::HEADER_LEN));
    end
  end

  // Objectness is signed, threshold unsigned: negative never passes
  assign kept = !objectness_next[dbf_pkg::VALUE_W-1] &&
                (objectness_next[dbf_pkg::VALUE_W-2:0] >
                 (dbf_pkg::VALUE_W-1)'(conf_threshold));
  assign done = anchor == (anchor_count - dbf_pkg::ANCHOR_W'(1));

  assign result_valid = row_end && (kept || done);

  always_comb begin
    result.kept         = kept;
    result.anchor_index = anchor;
    result.box_x        = box_next[0];
    result.box_y        = box_next[1];
    result.box_w        = box_next[2];
    result.box_h        = box_next[3];
    result.score        = objectness_next;
    result.class_index  = dbf_pkg::CLASS_ID_W'(best_class_next);
    result.frame_done   = done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      element_position <= '0;
      anchor_counter   <= '0;
      best_class       <= '0;
    end else if (step) begin
      best_class <= best_class_next;
      if (row_end) begin
        element_position <= '0;
        anchor_counter   <= done ? '0 : anchor + dbf_pkg::ANCHOR_W'(1);
      end else begin
        element_position <= pos + POS_W'(1);
        anchor_counter   <= anchor;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      box_store       <= box_next;
      objectness_hold <= objectness_next;
      best_score      <= best_score_next;
    end
  end

endmodule

`default_nettype wire

>>> tb/dbf_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbf_result_checker: scoreboard for the detection box filter
// Watches the element and result channels, keeps its own row and anchor state,
// and compares each result transaction field by field with the oldest
// prediction.
// ----------------------------------------------------------------------------
module dbf_result_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [dbf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [dbf_pkg::CFG_DATA_W-1:0]  cfg_data,
  dbf_in_if                               in_mon,
  dbf_out_if                              out_mon,
  output int                              mismatches,
  output int                              outstanding,
  output int                              results_seen,
  output int                              kept_seen,
  output int                              frames_closed
);

  localparam int REPORT_LIMIT = 10;

  // configuration copy
  logic [7:0]         class_count_q;
  logic [15:0]        anchor_count_q;
  logic [16:0]        threshold_q;

  // row state
  logic [8:0]         row_pos;
  logic [15:0]        row_anchor;
  logic signed [15:0] box_hold [dbf_pkg::BOX_FIELDS];
  logic signed [31:0] objectness_q;
  logic signed [31:0] best_score_q;
  logic [7:0]         best_class_q;

  dbf_pkg::dbf_result_t expected_results [$];
  dbf_pkg::dbf_result_t got;
  dbf_pkg::dbf_result_t want;
  string              diff;
  int                 error_count;
  int                 result_count;
  int                 kept_count;
  int                 frame_count;

  // integer part of a Q16.16 value, truncated toward zero
  function automatic logic signed [15:0] integer_part(input logic signed [31:0] q);
    logic signed [32:0] wide;
    logic [32:0]        mag;
    logic signed [15:0] part;
    wide = q;
    mag  = (wide < 0) ? -wide : wide;
    mag  = mag >> 16;
    part = mag[15:0];
    if (wide < 0) part = -part;
    return part;
  endfunction

  // advance the row state by one element; returns 1 when a result is due
  function automatic bit predict_row_end(input logic signed [31:0] v, input logic fs,
                                         output dbf_pkg::dbf_result_t res);
    int                 p;
    int                 row_last;
    bit                 keep;
    bit                 last_row;
    logic signed [32:0] obj_wide;
    logic signed [32:0] thr_wide;
    res = '0;
    if (fs) begin
      row_pos    = '0;
      row_anchor = '0;
    end
    p        = row_pos;
    row_last = class_count_q + dbf_pkg::HEADER_LEN - 1;

    if (p < dbf_pkg::BOX_FIELDS) begin
      box_hold[p] = integer_part(v);
    end else if (p == dbf_pkg::BOX_FIELDS) begin
      objectness_q = v;
      best_class_q = '0;
    end else if (p == dbf_pkg::HEADER_LEN) begin
      best_score_q = v;
      best_class_q = '0;
    end else if (v > best_score_q) begin
      best_score_q = v;
      best_class_q = 8'(p - dbf_pkg::HEADER_LEN);
    end

    if (p < row_last) begin
      row_pos = 9'(p + 1);
      return 1'b0;
    end

    row_pos  = '0;
    obj_wide = objectness_q;
    thr_wide = {16'd0, threshold_q};
    keep     = obj_wide > thr_wide;
    last_row = row_anchor == 16'(anchor_count_q - 16'd1);

    res.kept         = keep;
    res.anchor_index = row_anchor;
    res.box_x        = box_hold[0];
    res.box_y        = box_hold[1];
    res.box_w        = box_hold[2];
    res.box_h        = box_hold[3];
    res.score        = objectness_q;
    res.class_index  = best_class_q;
    res.frame_done   = last_row;

    row_anchor = last_row ? 16'd0 : row_anchor + 16'd1;
    return keep || last_row;
  endfunction

  task automatic log_mismatch(input string why, input dbf_pkg::dbf_result_t exp_r,
                              input dbf_pkg::dbf_result_t act_r);
    error_count++;
    if (error_count <= REPORT_LIMIT) begin
      $display("[%0t] result mismatch:%s", $realtime, why);
      $display("  expected kept=%0d anchor=%0d box=(%0d,%0d,%0d,%0d) score=%h class=%0d done=%0d",
               exp_r.kept, exp_r.anchor_index, exp_r.box_x, exp_r.box_y, exp_r.box_w,
               exp_r.box_h, exp_r.score, exp_r.class_index, exp_r.frame_done);
      $display("  actual   kept=%0d anchor=%0d box=(%0d,%0d,%0d,%0d) score=%h class=%0d done=%0d",
               act_r.kept, act_r.anchor_index, act_r.box_x, act_r.box_y, act_r.box_w,
               act_r.box_h, act_r.score, act_r.class_index, act_r.frame_done);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      class_count_q  <= 8'(dbf_pkg::CLASS_COUNT_RESET);
      anchor_count_q <= 16'(dbf_pkg::ANCHOR_COUNT_RESET);
      threshold_q    <= 17'(dbf_pkg::CONF_THRESHOLD_RESET);
      row_pos        = '0;
      row_anchor     = '0;
      for (int i = 0; i < dbf_pkg::BOX_FIELDS; i++) box_hold[i] = '0;
      objectness_q   = '0;
      best_score_q   = '0;
      best_class_q   = '0;
      expected_results.delete();
      error_count    = 0;
      result_count   = 0;
      kept_count     = 0;
      frame_count    = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          dbf_pkg::CFG_CLASS_COUNT:    class_count_q  <= cfg_data[7:0];
          dbf_pkg::CFG_ANCHOR_COUNT:   anchor_count_q <= cfg_data[15:0];
          dbf_pkg::CFG_CONF_THRESHOLD: threshold_q    <= cfg_data[16:0];
          default: ;
        endcase
      end

      // results first: a result at this edge always belongs to an older element
      if (out_mon.valid && out_mon.ready) begin
        got.kept         = out_mon.kept;
        got.anchor_index = out_mon.anchor_index;
        got.box_x        = out_mon.box_x;
        got.box_y        = out_mon.box_y;
        got.box_w        = out_mon.box_w;
        got.box_h        = out_mon.box_h;
        got.score        = out_mon.score;
        got.class_index  = out_mon.class_index;
        got.frame_done   = out_mon.frame_done;
        result_count++;
        if (got.kept) kept_count++;
        if (got.frame_done) frame_count++;
        if (expected_results.size() == 0) begin
          log_mismatch(" result with nothing expected", '0, got);
        end else begin
          want = expected_results.pop_front();
          diff = "";
          if (got.kept !== want.kept)                 diff = {diff, " kept"};
          if (got.anchor_index !== want.anchor_index) diff = {diff, " anchor_index"};
          if (got.box_x !== want.box_x)               diff = {diff, " box_x"};
          if (got.box_y !== want.box_y)               diff = {diff, " box_y"};
          if (got.box_w !== want.box_w)               diff = {diff, " box_w"};
          if (got.box_h !== want.box_h)               diff = {diff, " box_h"};
          if (got.score !== want.score)               diff = {diff, " score"};
          if (got.class_index !== want.class_index)   diff = {diff, " class_index"};
          if (got.frame_done !== want.frame_done)     diff = {diff, " frame_done"};
          if (diff != "") log_mismatch(diff, want, got);
        end
      end

      if (in_mon.valid && in_mon.ready) begin
        if (predict_row_end(in_mon.value, in_mon.frame_start, want))
          expected_results.insert(expected_results.size(), want);
      end
    end

    mismatches    <= error_count;
    outstanding   <= expected_results.size();
    results_seen  <= result_count;
    kept_seen     <= kept_count;
    frames_closed <= frame_count;
  end

endmodule

>>> tb/detection_box_filter_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// detection_box_filter_core_tb: stream test of the detection box filter
// Drives tensors of random rows under changing row lengths, anchor counts and
// thresholds, with sender gaps and receiver stalls, and leaves the checking
// to a scoreboard that predicts every result from its own row state.
// ----------------------------------------------------------------------------
module detection_box_filter_core_tb;

  localparam int CYCLE_LIMIT    = 200_000;
  localparam int SETTLE_CYCLES  = 8;     // result passes the input and result registers
  localparam int PHASE_ITEMS    = 200;
  localparam int RANDOM_PHASES  = 8;
  localparam int LONG_ROWS      = 40;    // rows of the tensor with anchor_count 0
  localparam int DIRECTED_ITEMS = 21;

  logic                            clk = 1'b0;
  logic                            rst;
  logic                            cfg_we;
  logic [dbf_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [dbf_pkg::CFG_DATA_W-1:0]  cfg_data;
  logic                            sink_ready = 1'b0;

  dbf_in_if  in_ch ();
  dbf_out_if out_ch ();

  // idling controls, in percent of cycles
  int send_idle_pct = 0;
  int stall_pct     = 0;

  // the settings the stimulus builds rows for
  int class_cnt;
  int anchor_cnt;
  int threshold;

  int elements_sent = 0;
  int settings_used = 0;
  int cycle_count   = 0;

  int mismatches;
  int outstanding;
  int results_seen;
  int kept_seen;
  int frames_closed;

  detection_box_filter_core DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .tensor_ch (in_ch),
    .result_ch (out_ch)
  );

  dbf_result_checker result_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .mismatches    (mismatches),
    .outstanding   (outstanding),
    .results_seen  (results_seen),
    .kept_seen     (kept_seen),
    .frames_closed (frames_closed)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Receiver: stall at random at the configured rate, hold ready high otherwise.
  always @(posedge clk) begin
    if (stall_pct == 0)
      sink_ready <= 1'b1;
    else
      sink_ready <= ($urandom_range(99, 0) >= stall_pct);
  end
  assign out_ch.ready = sink_ready;

  // Watchdog: drop out with a failure if the run hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still awaited", cycle_count,
               outstanding);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Pick an element value for position e of a row: box values mostly across the
  // full range, objectness often hugging the threshold, class scores often from
  // a narrow band so that ties are common.
  function automatic logic signed [31:0] rand_element(input int e);
    logic signed [31:0] v;
    if (e < dbf_pkg::BOX_FIELDS) begin
      if ($urandom_range(3, 0) == 0) begin
        v = $urandom_range(32'h0020_0000, 0);
        v = v - 32'sh0010_0000;
      end else begin
        v = $urandom;
      end
    end else if (e == dbf_pkg::BOX_FIELDS) begin
      case ($urandom_range(2, 0))
        0:       v = threshold + $urandom_range(4, 0) - 2;
        1:       v = $urandom_range(32'h0002_0000, 0);
        default: v = $urandom;
      endcase
    end else begin
      if ($urandom_range(1, 0) == 0)
        v = $urandom_range(6, 0) - 3;
      else
        v = $urandom;
    end
    return v;
  endfunction

  // Offer one element and hold it until the transaction completes. Valid is
  // only lowered when a gap is taken, so it never drops and rises in one step.
  task automatic send_element(input logic signed [31:0] v, input logic fs);
    while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.value       <= v;
    in_ch.frame_start <= fs;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    elements_sent++;
  endtask

  // Hold the sender until every predicted result has come back, then let the
  // pipeline settle in case an element that causes no result is still inside.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all three registers on consecutive edges; call only while drained.
  task automatic configure(input int cc, input int ac, input int thr);
    cfg_we    <= 1'b1;
    cfg_index <= dbf_pkg::CFG_CLASS_COUNT;
    cfg_data  <= dbf_pkg::CFG_DATA_W'(cc);
    @(posedge clk);
    cfg_index <= dbf_pkg::CFG_ANCHOR_COUNT;
    cfg_data  <= dbf_pkg::CFG_DATA_W'(ac);
    @(posedge clk);
    cfg_index <= dbf_pkg::CFG_CONF_THRESHOLD;
    cfg_data  <= dbf_pkg::CFG_DATA_W'(thr);
    @(posedge clk);
    cfg_we     <= 1'b0;
    class_cnt  = cc;
    anchor_cnt = (ac == 0) ? 65536 : ac;
    threshold  = thr;
    settings_used++;
  endtask

  // Stream mostly well-formed tensors with random content. Noise: a stray
  // frame start now and then, rows cut short and tensors cut short. Each phase
  // opens with a few elements that carry on whatever row the last phase left
  // open, so a row length change in mid-row gets exercised.
  task automatic stream_tensors(input int target);
    int  sent;
    int  rows;
    int  row_len;
    logic fs;
    sent = 0;
    repeat ($urandom_range(6, 2)) begin
      send_element(rand_element($urandom_range(8, 0)), 1'b0);
      sent++;
    end
    while (sent < target) begin
      rows = anchor_cnt;
      if ($urandom_range(9, 0) == 0) rows = $urandom_range(anchor_cnt, 1);
      row_len = class_cnt + dbf_pkg::HEADER_LEN;
      for (int a = 0; a < rows && sent < target; a++) begin
        for (int e = 0; e < row_len && sent < target; e++) begin
          fs = (a == 0 && e == 0) || ($urandom_range(199, 0) == 0);
          send_element(rand_element(e), fs);
          sent++;
          // occasional back-pressure from the sender side: wait for a full drain
          if ($urandom_range(299, 0) == 0) drain_results();
          if (e < row_len - 1 && $urandom_range(149, 0) == 0) break;
        end
      end
    end
  endtask

  // Directed rows at two classes and three anchors: box extremes, negative
  // values truncated toward zero, tied class scores (first one wins),
  // objectness just above and exactly at the top threshold (the latter is a
  // rejected row with no result), and a rejected last anchor that still closes
  // the tensor.
  logic signed [31:0] directed_rows [DIRECTED_ITEMS] = '{
    32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFE_FFFF,
    32'h0001_0001, 32'h0000_0007, 32'h0000_0007,
    32'h0001_8000, 32'hFFFE_8000, 32'h0000_0000, 32'h0000_FFFF,
    32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF,
    32'h0000_0000, 32'hFFFF_0000, 32'h7FFF_0000, 32'h8001_0000,
    32'h8000_0000, 32'hFFFF_FFFD, 32'hFFFF_FFFD
  };

  initial begin
    // Initialise every block input before the first edge.
    rst               <= 1'b1;
    cfg_we            <= 1'b0;
    cfg_index         <= dbf_pkg::CFG_CLASS_COUNT;
    cfg_data          <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.value       <= '0;
    in_ch.frame_start <= 1'b0;
    class_cnt          = dbf_pkg::CLASS_COUNT_RESET;
    anchor_cnt         = dbf_pkg::ANCHOR_COUNT_RESET;
    threshold          = dbf_pkg::CONF_THRESHOLD_RESET;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, no idling.
    configure(2, 3, 65536);
    for (int i = 0; i < DIRECTED_ITEMS; i++)
      send_element(directed_rows[i], i == 0);
    drain_results();

    // Random phases: cycle through the idling mixes while walking the settings
    // through their extremes (no classes, the full 255, one anchor, 65535
    // anchors, thresholds at both ends).
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph % 4)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 85; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 85; end
        default: begin send_idle_pct = 21; stall_pct = 21; end
      endcase
      case (ph)
        0:       configure(1, 4, 0);
        1:       configure(0, 3, 65536);
        2:       configure(5, 1, $urandom_range(65536, 0));
        3:       configure(255, 2, dbf_pkg::CONF_THRESHOLD_RESET);
        4:       configure($urandom_range(12, 1), 65535, $urandom_range(65536, 0));
        6:       configure($urandom_range(16, 0), $urandom_range(8, 1), 0);
        default: configure($urandom_range(16, 0), $urandom_range(8, 1),
                           $urandom_range(65536, 0));
      endcase
      stream_tensors(PHASE_ITEMS);
      drain_results();
    end

    // Tensor with anchor_count 0, taken as 65536 anchors: none of these rows
    // is the last anchor, so only kept rows return. Then one anchor per
    // tensor, so every row closes a tensor, kept or not.
    send_idle_pct = 0;
    stall_pct     = 0;
    configure(0, 0, dbf_pkg::CONF_THRESHOLD_RESET);
    for (int r = 0; r < LONG_ROWS; r++)
      for (int e = 0; e < dbf_pkg::HEADER_LEN; e++)
        send_element(rand_element(e), r == 0 && e == 0);
    drain_results();
    configure(0, 1, dbf_pkg::CONF_THRESHOLD_RESET);
    for (int r = 0; r < 2; r++)
      for (int e = 0; e < dbf_pkg::HEADER_LEN; e++)
        send_element(rand_element(e), r == 0 && e == 0);
    drain_results();

    $display("Summary: %0d element transactions under %0d settings, %0d results",
             elements_sent, settings_used, results_seen);
    $display("Summary: %0d kept, %0d tensor ends; class counts 0 to 255, anchor %s",
             kept_seen, frames_closed, "counts 1 to 65535 and 0, idle and stall mixes");
    if (mismatches == 0 && outstanding == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/dbf_pkg.sv
rtl/core/dbf_if.sv
rtl/core/dbf_row_tracker.sv
rtl/core/detection_box_filter_core.sv
tb/dbf_result_checker.sv
tb/detection_box_filter_core_tb.sv
